[design/assert_macros.svh]
// Assertion macros shared by the frame sync design.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define SFSU_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition in one cycle implies a property in the next.
`define SFSU_ASSERT_NEXT(label, cond, nxt, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (nxt)) else $error(msg);

`endif

[design/sfsu_pkg.sv]
// Package: constants, types and channel math for the frame sync unpacker.
package sfsu_pkg;

	localparam int BYTE_W      = 8;
	localparam int CH_W        = 11;
	localparam int SCH_W       = 12;
	localparam int FRAME_LEN   = 25;
	localparam int WIN_KEEP    = FRAME_LEN - 1;
	localparam int CNT_W       = $clog2(WIN_KEEP + 1);
	localparam int NUM_CH      = 10;
	localparam int PAYLOAD_B   = 14;
	localparam int PAYLOAD_W   = PAYLOAD_B * BYTE_W;
	localparam int DBAND_W     = 8;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 11;

	localparam logic [BYTE_W-1:0] FRAME_HEAD = 8'h0F;
	localparam logic [BYTE_W-1:0] FRAME_TAIL = 8'h00;

	localparam logic [CH_W-1:0]    CENTER_RST = 11'd1024;
	localparam logic [CH_W-1:0]    KNOB_RST   = 11'd353;
	localparam logic [CH_W-1:0]    LIMIT_RST  = 11'd1807;
	localparam logic [DBAND_W-1:0] DBAND_RST  = 8'd5;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CENTER   = 2'd0,
		CFG_KNOB     = 2'd1,
		CFG_LIMIT    = 2'd2,
		CFG_DEADBAND = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [CH_W-1:0]    center;
		logic [CH_W-1:0]    knob_ofs;
		logic [CH_W-1:0]    limit;
		logic [DBAND_W-1:0] dband;
	} sfsu_cfg_t;

	// Channel payload bytes 1..14 of a matched frame, byte 1 in the low bits.
	typedef struct packed {
		logic                 valid;
		logic [PAYLOAD_W-1:0] bits;
	} sfsu_frame_t;

	function automatic logic signed [SCH_W-1:0] stick_proc(
		input logic [CH_W-1:0]    raw,
		input logic [CH_W-1:0]    center,
		input logic [CH_W-1:0]    limit,
		input logic [DBAND_W-1:0] dband
	);
		logic signed [SCH_W-1:0] v;
		logic [SCH_W-1:0]        mag;
		v   = $signed({1'b0, raw}) - $signed({1'b0, center});
		mag = v[SCH_W-1] ? SCH_W'(-v) : SCH_W'(v);
		if ((mag <= {{(SCH_W-DBAND_W){1'b0}}, dband}) || (mag > {1'b0, limit}))
			return '0;
		return v;
	endfunction

	function automatic logic signed [SCH_W-1:0] knob_proc(
		input logic [CH_W-1:0] raw,
		input logic [CH_W-1:0] ofs
	);
		return $signed({1'b0, raw}) - $signed({1'b0, ofs});
	endfunction

endpackage

[design/sfsu_if.sv]
// Channel interfaces: received bytes, decoded frames, register writes.
interface sfsu_byte_if;
	logic                        valid;
	logic                        ready;
	logic [sfsu_pkg::BYTE_W-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfsu_frame_if;
	logic                              valid;
	logic                              ready;
	logic signed [sfsu_pkg::SCH_W-1:0] stick_ch1;
	logic signed [sfsu_pkg::SCH_W-1:0] stick_ch2;
	logic signed [sfsu_pkg::SCH_W-1:0] stick_ch3;
	logic signed [sfsu_pkg::SCH_W-1:0] stick_ch4;
	logic [sfsu_pkg::CH_W-1:0]         switch_ch5;
	logic [sfsu_pkg::CH_W-1:0]         switch_ch6;
	logic [sfsu_pkg::CH_W-1:0]         switch_ch7;
	logic [sfsu_pkg::CH_W-1:0]         switch_ch8;
	logic signed [sfsu_pkg::SCH_W-1:0] knob_ch9;
	logic signed [sfsu_pkg::SCH_W-1:0] knob_ch10;

	modport source (
		output valid, input ready,
		output stick_ch1, output stick_ch2, output stick_ch3, output stick_ch4,
		output switch_ch5, output switch_ch6, output switch_ch7, output switch_ch8,
		output knob_ch9, output knob_ch10
	);
	modport sink (
		input valid, output ready,
		input stick_ch1, input stick_ch2, input stick_ch3, input stick_ch4,
		input switch_ch5, input switch_ch6, input switch_ch7, input switch_ch8,
		input knob_ch9, input knob_ch10
	);
endinterface

interface sfsu_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [sfsu_pkg::CFG_IDX_W-1:0]  index;
	logic [sfsu_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

[design/sbus_frame_sync_channel_unpack_core.sv]
// Top level: frame sync channel unpacker.
// Throughput: one byte per cycle while rx.ready is high (low when a pending frame is
// held by a stalled result stage); window shift and marker compare in the accept cycle.
// Path: closing byte goes to the frame stage register, then to the result register.
// Reset: window count, stage valids and config registers cleared to defaults;
// window bytes not reset.
module sbus_frame_sync_channel_unpack_core (
	input  logic         clk,
	input  logic         arst_n,
	sfsu_byte_if.sink    rx,
	sfsu_frame_if.source frm,
	sfsu_cfg_if.sink     cfg
);
	import sfsu_pkg::*;

	sfsu_cfg_t   regs;
	sfsu_frame_t frame;
	logic        take;

	sfsu_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	sfsu_window u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx),
		.take   (take),
		.frame  (frame)
	);

	sfsu_decode u_decode (
		.clk    (clk),
		.arst_n (arst_n),
		.frame  (frame),
		.regs   (regs),
		.take   (take),
		.frm    (frm)
	);

endmodule

[design/sfsu_cfg.sv]
// Configuration register file with write channel.
module sfsu_cfg (
	input  logic                clk,
	input  logic                arst_n,
	sfsu_cfg_if.sink            cfg,
	output sfsu_pkg::sfsu_cfg_t regs
);
	import sfsu_pkg::*;

	sfsu_cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.center   <= CENTER_RST;
			regs_q.knob_ofs <= KNOB_RST;
			regs_q.limit    <= LIMIT_RST;
			regs_q.dband    <= DBAND_RST;
		end else if (cfg.valid) begin
			case (cfg_idx_t'(cfg.index))
				CFG_CENTER:   regs_q.center   <= cfg.data[CH_W-1:0];
				CFG_KNOB:     regs_q.knob_ofs <= cfg.data[CH_W-1:0];
				CFG_LIMIT:    regs_q.limit    <= cfg.data[CH_W-1:0];
				CFG_DEADBAND: regs_q.dband    <= cfg.data[DBAND_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

[design/sfsu_window.sv]
// Byte window shift line, fill count, marker check and frame stage register.
`include "assert_macros.svh"

module sfsu_window (
	input  logic                  clk,
	input  logic                  arst_n,
	sfsu_byte_if.sink             rx,
	input  logic                  take,
	output sfsu_pkg::sfsu_frame_t frame
);
	import sfsu_pkg::*;

	logic [BYTE_W-1:0] win_q [WIN_KEEP];
	logic [CNT_W-1:0]  cnt_q;
	logic              frame_valid_s1;
	logic [PAYLOAD_W-1:0] frame_bits_s1;
	logic              acc;
	logic              full;
	logic              hit;
	logic [PAYLOAD_W-1:0] payload;

	assign rx.ready = !frame_valid_s1 || take;
	assign acc      = rx.valid && rx.ready;
	assign full     = (cnt_q == CNT_W'(WIN_KEEP));
	assign hit      = full && (win_q[0] == FRAME_HEAD) && (rx.rx_byte == FRAME_TAIL);
	assign frame    = '{valid: frame_valid_s1, bits: frame_bits_s1};

	always_comb begin
		for (int k = 0; k < PAYLOAD_B; k++)
			payload[k*BYTE_W +: BYTE_W] = win_q[k+1];
	end

	// newest byte at the top, oldest held byte at index 0 once full
	always_ff @(posedge clk) begin
		if (acc) begin
			for (int i = 0; i < WIN_KEEP - 1; i++)
				win_q[i] <= win_q[i+1];
			win_q[WIN_KEEP-1] <= rx.rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (acc) begin
			if (hit)
				cnt_q <= '0;
			else if (!full)
				cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			frame_valid_s1 <= acc && hit;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && hit)
			frame_bits_s1 <= payload;
	end

	`SFSU_ASSERT(a_cnt_range, cnt_q <= CNT_W'(WIN_KEEP), "window count past capacity")
	`SFSU_ASSERT_NEXT(a_match_clears, acc && hit, cnt_q == '0, "window not emptied on frame")
	`SFSU_ASSERT_NEXT(a_frame_holds, frame_valid_s1 && !take,
		frame_valid_s1 && $stable(frame_bits_s1), "pending frame lost")

endmodule

[design/sfsu_decode.sv]
// Channel unpack, stick/knob conditioning and result register.
module sfsu_decode (
	input  logic                  clk,
	input  logic                  arst_n,
	input  sfsu_pkg::sfsu_frame_t frame,
	input  sfsu_pkg::sfsu_cfg_t   regs,
	output logic                  take,
	sfsu_frame_if.source          frm
);
	import sfsu_pkg::*;

	logic [CH_W-1:0]         ch [NUM_CH];
	logic                    out_valid_q;
	logic signed [SCH_W-1:0] stick_q [4];
	logic [CH_W-1:0]         switch_q [4];
	logic signed [SCH_W-1:0] knob_q [2];

	assign take = !out_valid_q || frm.ready;

	always_comb begin
		for (int k = 0; k < NUM_CH; k++)
			ch[k] = frame.bits[k*CH_W +: CH_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (take)
			out_valid_q <= frame.valid;
	end

	always_ff @(posedge clk) begin
		if (take && frame.valid) begin
			for (int i = 0; i < 4; i++) begin
				stick_q[i]  <= stick_proc(ch[i], regs.center, regs.limit, regs.dband);
				switch_q[i] <= ch[i+4];
			end
			for (int j = 0; j < 2; j++)
				knob_q[j] <= knob_proc(ch[j+8], regs.knob_ofs);
		end
	end

	assign frm.valid      = out_valid_q;
	assign frm.stick_ch1  = stick_q[0];
	assign frm.stick_ch2  = stick_q[1];
	assign frm.stick_ch3  = stick_q[2];
	assign frm.stick_ch4  = stick_q[3];
	assign frm.switch_ch5 = switch_q[0];
	assign frm.switch_ch6 = switch_q[1];
	assign frm.switch_ch7 = switch_q[2];
	assign frm.switch_ch8 = switch_q[3];
	assign frm.knob_ch9   = knob_q[0];
	assign frm.knob_ch10  = knob_q[1];

endmodule
